/* rtl/rgb_to_hsv_pixel_converter_unit_assert.svh */
// Assertion macros shared by the converter modules.
`ifndef RGB_TO_HSV_PIXEL_CONVERTER_UNIT_ASSERT_SVH
`define RGB_TO_HSV_PIXEL_CONVERTER_UNIT_ASSERT_SVH

// Same-cycle implication, skipped while reset is high.
`define RHSV_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, skipped while reset is high.
`define RHSV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/rhsv_pkg.sv */
package rhsv_pkg;

  localparam int PIX_W     = 8;
  localparam int NUM_W     = 16;
  localparam int QUOT_BITS = 8;

  localparam int HUE_SCALE = 30;
  localparam int HUE_GREEN = 60;
  localparam int HUE_BLUE  = 120;
  localparam int HUE_SPAN  = 180;

  // Word handed from cell to cell: two partial divisions and the value channel.
  typedef struct packed {
    logic [NUM_W-1:0] hue_rem;
    logic [NUM_W-1:0] sat_rem;
    logic [PIX_W-1:0] hue_div;
    logic [PIX_W-1:0] sat_div;
    logic [PIX_W-1:0] hue_q;
    logic [PIX_W-1:0] sat_q;
    logic [PIX_W-1:0] bright;
  } rhsv_word_t;

endpackage

/* rtl/rgb_to_hsv_pixel_converter_unit.sv */
// RGB to HSV pixel converter, 8 bits per channel.
//
// Input channel: blue, green, red with in_valid / in_ready. Output channel:
// hue (0..179, two-degree units), saturation (0..255), brightness (max of
// the three) with out_valid / out_ready. A word moves on a channel at each
// rising edge where its valid and ready are both high.
//
// Structure: a preparation register finds max, min and delta and forms the
// two numerators; then a row of eight divider cells each settles one quotient
// bit, most significant first, for hue and saturation side by side.
// Throughput: one pixel per cycle while out_ready stays high; each cell holds one word and passes it on
// whenever the next cell can take it, so the row is fully pipelined.
// Stalls: when out_ready is low the last cell holds its word, and each cell
// upstream keeps accepting until it too is full, so bubbles get squeezed out
// before in_ready drops. Reset clears every valid bit; no words are kept.
module rgb_to_hsv_pixel_converter_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [rhsv_pkg::PIX_W-1:0] blue,
  input  logic [rhsv_pkg::PIX_W-1:0] green,
  input  logic [rhsv_pkg::PIX_W-1:0] red,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [rhsv_pkg::PIX_W-1:0] hue,
  output logic [rhsv_pkg::PIX_W-1:0] saturation,
  output logic [rhsv_pkg::PIX_W-1:0] brightness
);
  import rhsv_pkg::*;

  `include "rgb_to_hsv_pixel_converter_unit_assert.svh"

  // Links between stages: index 0 leaves the prep register, the last one
  // leaves the final divider cell and drives the ports.
  logic       link_valid [QUOT_BITS+1];
  logic       link_ready [QUOT_BITS+1];
  rhsv_word_t link_data  [QUOT_BITS+1];

  rhsv_prep u_prep (
    .clk      (clk),
    .rst      (rst),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .blue     (blue),
    .green    (green),
    .red      (red),
    .dn_valid (link_valid[0]),
    .dn_ready (link_ready[0]),
    .dn_data  (link_data[0])
  );

  // Cell k settles quotient bit QUOT_BITS-1-k.
  for (genvar k = 0; k < QUOT_BITS; k++) begin : g_cell
    rhsv_div_cell #(
      .BIT (QUOT_BITS - 1 - k)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (link_valid[k]),
      .up_ready (link_ready[k]),
      .up_data  (link_data[k]),
      .dn_valid (link_valid[k+1]),
      .dn_ready (link_ready[k+1]),
      .dn_data  (link_data[k+1])
    );
  end

  // Last cell register doubles as the output register.
  assign link_ready[QUOT_BITS] = out_ready;
  assign out_valid  = link_valid[QUOT_BITS];
  assign hue        = link_data[QUOT_BITS].hue_q;
  assign saturation = link_data[QUOT_BITS].sat_q;
  assign brightness = link_data[QUOT_BITS].bright;

  `RHSV_ASSERT_IMPLY(a_hue_range, clk, rst, out_valid,
    hue < PIX_W'(HUE_SPAN), "hue out of range")
  `RHSV_ASSERT_IMPLY(a_black_pixel, clk, rst, out_valid && (brightness == '0),
    (saturation == '0) && (hue == '0), "black pixel gave nonzero hue or saturation")

endmodule

/* rtl/rhsv_prep.sv */
module rhsv_prep (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      up_valid,
  output logic                      up_ready,
  input  logic [rhsv_pkg::PIX_W-1:0] blue,
  input  logic [rhsv_pkg::PIX_W-1:0] green,
  input  logic [rhsv_pkg::PIX_W-1:0] red,
  output logic                      dn_valid,
  input  logic                      dn_ready,
  output rhsv_pkg::rhsv_word_t      dn_data
);
  import rhsv_pkg::*;

  logic       valid;
  rhsv_word_t data;
  rhsv_word_t data_next;

  always_comb begin
    logic [PIX_W-1:0] mx;
    logic [PIX_W-1:0] mn;
    logic [PIX_W-1:0] d;
    logic [NUM_W-1:0] d_w;
    logic [NUM_W-1:0] num;
    mx  = (red > green) ? red : green;
    mx  = (mx > blue) ? mx : blue;
    mn  = (red < green) ? red : green;
    mn  = (mn < blue) ? mn : blue;
    d   = mx - mn;
    d_w = NUM_W'(d);
    // Offset each sector so the numerator never goes negative.
    priority if (mx == red) begin
      if (green >= blue) num = NUM_W'(HUE_SCALE) * NUM_W'(green - blue);
      else num = NUM_W'(HUE_SPAN) * d_w - NUM_W'(HUE_SCALE) * NUM_W'(blue - green);
    end else if (mx == green) begin
      if (blue >= red) num = NUM_W'(HUE_GREEN) * d_w + NUM_W'(HUE_SCALE) * NUM_W'(blue - red);
      else num = NUM_W'(HUE_GREEN) * d_w - NUM_W'(HUE_SCALE) * NUM_W'(red - blue);
    end else begin
      if (red >= green) num = NUM_W'(HUE_BLUE) * d_w + NUM_W'(HUE_SCALE) * NUM_W'(red - green);
      else num = NUM_W'(HUE_BLUE) * d_w - NUM_W'(HUE_SCALE) * NUM_W'(green - red);
    end
    data_next.hue_rem = num;
    data_next.sat_rem = (d_w << PIX_W) - d_w;
    // A zero divisor only occurs with a zero numerator; use one to get a zero quotient.
    data_next.hue_div = (d == '0) ? PIX_W'(1) : d;
    data_next.sat_div = (mx == '0) ? PIX_W'(1) : mx;
    data_next.hue_q   = '0;
    data_next.sat_q   = '0;
    data_next.bright  = mx;
  end

  assign up_ready = !valid || dn_ready;
  assign dn_valid = valid;
  assign dn_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data <= data_next;
    end
  end

endmodule

/* rtl/rhsv_div_cell.sv */
module rhsv_div_cell #(
  parameter int BIT = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  rhsv_pkg::rhsv_word_t up_data,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output rhsv_pkg::rhsv_word_t dn_data
);
  import rhsv_pkg::*;

  `include "rgb_to_hsv_pixel_converter_unit_assert.svh"

  logic             valid;
  rhsv_word_t       data;
  rhsv_word_t       data_next;
  logic [NUM_W-1:0] hue_step;
  logic [NUM_W-1:0] sat_step;

  assign hue_step = NUM_W'(up_data.hue_div) << BIT;
  assign sat_step = NUM_W'(up_data.sat_div) << BIT;

  // One restoring step on each lane: subtract the shifted divisor if it fits.
  always_comb begin
    data_next = up_data;
    if (up_data.hue_rem >= hue_step) begin
      data_next.hue_rem    = up_data.hue_rem - hue_step;
      data_next.hue_q[BIT] = 1'b1;
    end
    if (up_data.sat_rem >= sat_step) begin
      data_next.sat_rem    = up_data.sat_rem - sat_step;
      data_next.sat_q[BIT] = 1'b1;
    end
  end

  assign up_ready = !valid || dn_ready;
  assign dn_valid = valid;
  assign dn_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data <= data_next;
    end
  end

  `RHSV_ASSERT_IMPLY(a_hue_rem_bound, clk, rst, valid,
    data.hue_rem < (NUM_W'(data.hue_div) << BIT), "hue remainder not reduced")
  `RHSV_ASSERT_IMPLY(a_sat_rem_bound, clk, rst, valid,
    data.sat_rem < (NUM_W'(data.sat_div) << BIT), "saturation remainder not reduced")

endmodule

/* verif/tb_top.sv */
module tb_top;

  import rhsv_pkg::*;

  typedef logic [PIX_W-1:0] chan_t;

  typedef struct packed {
    chan_t hue;
    chan_t sat;
    chan_t bright;
  } hsv_pixel_t;

  // Scoreboard: predicts the HSV word for each accepted pixel and matches
  // output words against the oldest prediction, in order.
  class hsv_pixel_scoreboard;
    hsv_pixel_t  pending_hsv_q[$];
    int unsigned fail_count;

    function new();
      fail_count = 0;
    endfunction

    static function hsv_pixel_t rgb_to_hsv_expected(chan_t b, chan_t g, chan_t r);
      int unsigned ib, ig, ir, mx, mn, d, num;
      hsv_pixel_t  px;
      ib = 32'(b);
      ig = 32'(g);
      ir = 32'(r);
      mx = ir;
      if (ig > mx) mx = ig;
      if (ib > mx) mx = ib;
      mn = ir;
      if (ig < mn) mn = ig;
      if (ib < mn) mn = ib;
      d = mx - mn;
      px.hue    = '0;
      px.sat    = '0;
      px.bright = chan_t'(mx);
      if (d != 0) begin
        // Offset each numerator so it stays nonnegative; floor is then plain division.
        if (mx == ir) begin
          if (ig >= ib) num = HUE_SCALE * (ig - ib);
          else          num = HUE_SPAN * d - HUE_SCALE * (ib - ig);
        end else if (mx == ig) begin
          if (ib >= ir) num = HUE_GREEN * d + HUE_SCALE * (ib - ir);
          else          num = HUE_GREEN * d - HUE_SCALE * (ir - ib);
        end else begin
          if (ir >= ig) num = HUE_BLUE * d + HUE_SCALE * (ir - ig);
          else          num = HUE_BLUE * d - HUE_SCALE * (ig - ir);
        end
        px.hue = chan_t'(num / d);
      end
      if (mx != 0) px.sat = chan_t'((255 * d) / mx);
      return px;
    endfunction

    function void note_pixel(chan_t b, chan_t g, chan_t r);
      pending_hsv_q.push_back(rgb_to_hsv_expected(b, g, r));
    endfunction

    function void check_result(chan_t h, chan_t s, chan_t v);
      hsv_pixel_t want;
      if (pending_hsv_q.size() == 0) begin
        $error("output word with no pixel pending: hue %0d sat %0d value %0d", h, s, v);
        fail_count++;
        return;
      end
      want = pending_hsv_q.pop_front();
      if (h !== want.hue) begin
        $error("hue: expected %0d, got %0d", want.hue, h);
        fail_count++;
      end
      if (s !== want.sat) begin
        $error("saturation: expected %0d, got %0d", want.sat, s);
        fail_count++;
      end
      if (v !== want.bright) begin
        $error("brightness: expected %0d, got %0d", want.bright, v);
        fail_count++;
      end
    endfunction

    function int pending();
      return pending_hsv_q.size();
    endfunction
  endclass

  localparam int unsigned CYCLE_LIMIT = 200000;
  // Pipeline depth plus margin.
  localparam int unsigned DRAIN_CYCLES = 20;

  logic  clk       = 1'b0;
  logic  rst       = 1'b1;
  logic  in_valid  = 1'b0;
  logic  in_ready;
  chan_t blue      = '0;
  chan_t green     = '0;
  chan_t red       = '0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  chan_t hue;
  chan_t saturation;
  chan_t brightness;

  int unsigned tx_idle_pct    = 0;
  int unsigned rx_idle_pct    = 0;
  int unsigned rx_hold_cycles = 0;
  int unsigned cycle_count    = 0;

  hsv_pixel_scoreboard hsv_sb = new();

  rgb_to_hsv_pixel_converter_unit u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .blue       (blue),
    .green      (green),
    .red        (red),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness)
  );

  always #10 clk = ~clk;

  // Hard stop in case the pipeline wedges.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Watch both channels; values read here are the ones present at the edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) hsv_sb.note_pixel(blue, green, red);
      if (out_valid && out_ready) hsv_sb.check_result(hue, saturation, brightness);
    end
  end

  // Output side: random backpressure, or a long hold when the stimulus asks for one.
  initial begin
    int unsigned hold_left;
    forever begin
      @(posedge clk);
      if (rx_hold_cycles != 0) begin
        hold_left      = rx_hold_cycles;
        rx_hold_cycles = 0;
        out_ready <= 1'b0;
        repeat (hold_left) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Offer one pixel and hold it until the converter takes it.
  task automatic send_pixel(input chan_t b, input chan_t g, input chan_t r);
    in_valid <= 1'b1;
    blue     <= b;
    green    <= g;
    red      <= r;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and wait for every pending pixel to come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (hsv_sb.pending() != 0);
  endtask

  function automatic chan_t extreme_value();
    case ($urandom_range(5))
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return 8'd127;
      3:       return 8'd128;
      4:       return 8'd254;
      default: return 8'd255;
    endcase
  endfunction

  // Mix uniform pixels with grays, ties for the maximum, extremes, small deltas and pixels with one channel at zero.
  task automatic pick_pixel(output chan_t b, output chan_t g, output chan_t r);
    int unsigned kind, top, other, base;
    kind = $urandom_range(99);
    if (kind < 50) begin
      b = chan_t'($urandom);
      g = chan_t'($urandom);
      r = chan_t'($urandom);
    end else if (kind < 60) begin
      b = chan_t'($urandom);
      g = b;
      r = b;
    end else if (kind < 72) begin
      top   = $urandom_range(1, 255);
      other = $urandom_range(0, top);
      case ($urandom_range(2))
        0: begin r = chan_t'(top); g = chan_t'(top); b = chan_t'(other); end
        1: begin g = chan_t'(top); b = chan_t'(top); r = chan_t'(other); end
        default: begin r = chan_t'(top); b = chan_t'(top); g = chan_t'(other); end
      endcase
    end else if (kind < 80) begin
      b = extreme_value();
      g = extreme_value();
      r = extreme_value();
    end else if (kind < 90) begin
      base = $urandom_range(0, 252);
      b = chan_t'(base + $urandom_range(3));
      g = chan_t'(base + $urandom_range(3));
      r = chan_t'(base + $urandom_range(3));
    end else begin
      b = chan_t'($urandom);
      g = chan_t'($urandom);
      r = chan_t'($urandom);
      case ($urandom_range(2))
        0:       b = '0;
        1:       g = '0;
        default: r = '0;
      endcase
    end
  endtask

  task automatic send_random(input int unsigned count);
    chan_t b, g, r;
    for (int unsigned i = 0; i < count; i++) begin
      // Idle between words at the sender's rate.
      while ($urandom_range(99) < tx_idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      pick_pixel(b, g, r);
      send_pixel(b, g, r);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed pixels: black, white, gray, primaries, every max branch with
    // both signs of the hue difference, ties, and unit deltas.
    send_pixel(8'd0,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd0,   8'd0,   8'd255);
    send_pixel(8'd0,   8'd255, 8'd0);
    send_pixel(8'd255, 8'd0,   8'd0);
    send_pixel(8'd0,   8'd200, 8'd255);
    send_pixel(8'd1,   8'd0,   8'd255);
    send_pixel(8'd200, 8'd255, 8'd0);
    send_pixel(8'd0,   8'd255, 8'd1);
    send_pixel(8'd255, 8'd0,   8'd200);
    send_pixel(8'd255, 8'd1,   8'd0);
    send_pixel(8'd0,   8'd255, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd255, 8'd0,   8'd255);
    send_pixel(8'd0,   8'd1,   8'd1);
    send_pixel(8'd0,   8'd0,   8'd1);
    send_pixel(8'd254, 8'd255, 8'd254);
    send_pixel(8'd255, 8'd254, 8'd254);
    send_pixel(8'd170, 8'd85,  8'd255);
    send_pixel(8'd85,  8'd170, 8'd1);
    send_pixel(8'd1,   8'd2,   8'd3);

    // Pause the sender until the pipeline is empty.
    wait_drained();

    tx_idle_pct = 26;
    rx_idle_pct = 61;
    send_random(400);

    // Long output hold while the sender keeps offering, so in_ready drops.
    tx_idle_pct    = 0;
    rx_idle_pct    = 0;
    rx_hold_cycles = 120;
    send_random(80);
    wait_drained();

    tx_idle_pct = 61;
    rx_idle_pct = 26;
    send_random(400);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_random(370);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (hsv_sb.fail_count == 0 && hsv_sb.pending() == 0) begin
      $display("PASS");
    end else begin
      if (hsv_sb.pending() != 0)
        $error("%0d expected words never came out", hsv_sb.pending());
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/rhsv_pkg.sv
rtl/rhsv_prep.sv
rtl/rhsv_div_cell.sv
rtl/rgb_to_hsv_pixel_converter_unit.sv
verif/tb_top.sv
